// ===== hdl/voxel_occupancy_bitmap_assert.svh =====
// Assertion macros used by the voxel occupancy bitmap back end.
`ifndef VOXEL_OCCUPANCY_BITMAP_ASSERT_SVH
`define VOXEL_OCCUPANCY_BITMAP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define VOB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define VOB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/vob_pkg.sv =====
// Package with the types, constants and address functions of the voxel occupancy bitmap.
`timescale 1ns / 1ps

package vob_pkg;

    // Geometry of the map.
    localparam int CHUNK_EDGE   = 16;
    localparam int GRID_EDGE    = 2;
    localparam int CHUNK_VOXELS = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
    localparam int MAP_DEPTH    = GRID_EDGE * GRID_EDGE * GRID_EDGE * CHUNK_VOXELS;
    localparam int ADDR_W       = $clog2(MAP_DEPTH);
    localparam int SPAN         = GRID_EDGE * CHUNK_EDGE;
    localparam int SPAN_W       = $clog2(SPAN);
    localparam int CHUNK_W      = (GRID_EDGE > 1) ? $clog2(GRID_EDGE) : 1;
    localparam int OFF_W        = $clog2(CHUNK_EDGE);

    // Item field widths.
    localparam int ACT_W     = 2;
    localparam int POS_W     = 16;
    localparam int IN_DATA_W = 3 * POS_W;
    localparam int OUT_DATA_W = 8;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_QUERY     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SET       = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR     = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR_ALL = 2'd3;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One axis split into chunk number and offset.
    typedef struct packed {
        logic               in_grid;
        logic [CHUNK_W-1:0] chunk;
        logic [OFF_W-1:0]   offset;
    } t_axis;

    // A classified item as it waits in the queue.
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic              in_grid;
        logic [ADDR_W-1:0] addr;
    } t_item;

    // Status the back reports to the front.
    typedef struct packed {
        logic clearing;
    } t_back_status;

    // Floor-divides one coordinate by the chunk edge, biased by one chunk.
    // Only coordinates in -CHUNK_EDGE .. SPAN-CHUNK_EDGE-1 land in the grid,
    // so the division works on a narrow biased value with a few compares.
    function automatic t_axis split_axis(input logic signed [POS_W-1:0] pos);
        t_axis                    res;
        logic signed [POS_W+1:0]  biased;
        logic [SPAN_W-1:0]        u;
        logic [CHUNK_W-1:0]       ch;
        biased = $signed({{2{pos[POS_W-1]}}, pos}) + $signed((POS_W+2)'(CHUNK_EDGE));
        res.in_grid = (biased >= 0) && (biased < SPAN);
        u  = biased[SPAN_W-1:0];
        ch = '0;
        for (int k = 1; k < GRID_EDGE; k++) begin
            if (u >= SPAN_W'(k * CHUNK_EDGE)) begin
                ch = CHUNK_W'(k);
            end
        end
        res.chunk  = ch;
        res.offset = OFF_W'(u - SPAN_W'(int'(ch) * CHUNK_EDGE));
        return res;
    endfunction

    // Linear bit address: chunk index times chunk size plus in-chunk index.
    function automatic logic [ADDR_W-1:0] make_addr(input t_axis ax, input t_axis ay,
                                                    input t_axis az);
        int grid_idx;
        int vox_idx;
        grid_idx = (int'(ay.chunk) * GRID_EDGE + int'(az.chunk)) * GRID_EDGE
                   + int'(ax.chunk);
        vox_idx  = (int'(ay.offset) * CHUNK_EDGE + int'(az.offset)) * CHUNK_EDGE
                   + int'(ax.offset);
        return ADDR_W'(grid_idx * CHUNK_VOXELS + vox_idx);
    endfunction

endpackage

// ===== hdl/voxel_occupancy_bitmap.sv =====
// Top level of the voxel occupancy bitmap.
// The block keeps one solid bit per voxel over a 2x2x2 grid of 16x16x16-voxel chunks
// (32768 bits in one RAM) and performs query, set, clear or clear-all per item.
// After reset and after every clear-all the map is swept to zero, one bit per
// cycle; no item is accepted during the sweep. A query reads its bit from the
// registered read port of the map RAM, so it passes through a read state before
// its result is loaded; a set, clear or out-of-grid item loads its result at once,
// and a clear-all loads its result and then starts the sweep. A two-entry queue
// lets items be accepted while a result waits in the output register.
`timescale 1ns / 1ps

module voxel_occupancy_bitmap (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0: pos_x[15:0], pos_y[15:0], pos_z[15:0].
    input  logic [vob_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // Fields from bit 0: action[1:0].
    input  logic [vob_pkg::ACT_W-1:0]       s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0: solid, inside_res, then zero fill.
    output logic [vob_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    vob_pkg::t_back_status status;
    vob_pkg::t_item        push_item;
    vob_pkg::t_item        head_item;
    logic                  push;
    logic                  queue_full;
    logic                  head_valid;
    logic                  pop;

    vob_front u_front (
        .i_s_tvalid  (s_axis_tvalid),
        .o_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_status    (status),
        .i_queue_full(queue_full),
        .o_push      (push),
        .o_item      (push_item)
    );

    vob_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (push_item),
        .o_full      (queue_full),
        .o_head_valid(head_valid),
        .o_head      (head_item),
        .i_pop       (pop)
    );

    vob_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head_valid(head_valid),
        .i_head      (head_item),
        .o_pop       (pop),
        .o_status    (status),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule

// ===== hdl/vob_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module vob_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/vob_front.sv =====
// Front end: accepts input items and turns coordinates into a bit address.
`timescale 1ns / 1ps

module vob_front (
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [vob_pkg::IN_DATA_W-1:0]   i_s_tdata,
    input  logic [vob_pkg::ACT_W-1:0]       i_s_tuser,
    input  vob_pkg::t_back_status           i_status,
    input  logic                            i_queue_full,
    output logic                            o_push,
    output vob_pkg::t_item                  o_item
);

    vob_pkg::t_axis ax;
    vob_pkg::t_axis ay;
    vob_pkg::t_axis az;

    // Items are held off while the queue is full or the map is being swept.
    assign o_s_tready = !i_queue_full && !i_status.clearing;
    assign o_push     = i_s_tvalid && o_s_tready;

    // Split each axis and form the in-grid flag and the bit address.
    always_comb begin
        ax = vob_pkg::split_axis(i_s_tdata[vob_pkg::POS_W-1:0]);
        ay = vob_pkg::split_axis(i_s_tdata[2*vob_pkg::POS_W-1:vob_pkg::POS_W]);
        az = vob_pkg::split_axis(i_s_tdata[3*vob_pkg::POS_W-1:2*vob_pkg::POS_W]);
        o_item.action  = i_s_tuser;
        o_item.in_grid = ax.in_grid && ay.in_grid && az.in_grid;
        o_item.addr    = vob_pkg::make_addr(ax, ay, az);
    end

endmodule

// ===== hdl/vob_queue.sv =====
// Short FIFO of classified items between the front and the back.
`timescale 1ns / 1ps

module vob_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  vob_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_head_valid,
    output vob_pkg::t_item o_head,
    input  logic           i_pop
);

    vob_pkg::t_item                r_mem [vob_pkg::QUEUE_DEPTH];
    logic [vob_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [vob_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [vob_pkg::QCNT_W-1:0]    r_count;
    logic [vob_pkg::QPTR_W-1:0]    n_wr_ptr;
    logic [vob_pkg::QPTR_W-1:0]    n_rd_ptr;
    logic [vob_pkg::QCNT_W-1:0]    n_count;

    localparam logic [vob_pkg::QPTR_W-1:0] PTR_LAST = vob_pkg::QPTR_W'(vob_pkg::QUEUE_DEPTH - 1);

    assign o_full       = (r_count == vob_pkg::QCNT_W'(vob_pkg::QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + vob_pkg::QPTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + vob_pkg::QPTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + vob_pkg::QCNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - vob_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage carries no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== hdl/vob_back.sv =====
// Back end: carries out queued actions on the bit map and drives the result register.
`timescale 1ns / 1ps
`include "voxel_occupancy_bitmap_assert.svh"

module vob_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_head_valid,
    input  vob_pkg::t_item                   i_head,
    output logic                             o_pop,
    output vob_pkg::t_back_status            o_status,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [vob_pkg::OUT_DATA_W-1:0]   o_m_tdata
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;

    localparam logic [vob_pkg::ADDR_W-1:0] CLR_LAST = vob_pkg::ADDR_W'(vob_pkg::MAP_DEPTH - 1);

    logic [1:0]                  r_state;
    logic [1:0]                  n_state;
    logic [vob_pkg::ADDR_W-1:0]  r_clr_cnt;
    logic [vob_pkg::ADDR_W-1:0]  n_clr_cnt;
    logic                        r_m_valid;
    logic                        r_solid;
    logic                        r_inside;

    logic                        out_free;
    logic                        load;
    logic                        load_solid;
    logic                        load_inside;
    logic                        ram_we;
    logic [vob_pkg::ADDR_W-1:0]  ram_waddr;
    logic [0:0]                  ram_wdata;
    logic                        ram_re;
    logic [0:0]                  ram_rdata;

    assign out_free = !r_m_valid || i_m_tready;

    // Sequencer: sweep after reset and clear-all, writes issued straight from idle,
    // queries through the registered read port and the read state.
    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        o_pop       = 1'b0;
        load        = 1'b0;
        load_solid  = 1'b0;
        load_inside = i_head.in_grid;
        ram_we      = 1'b0;
        ram_waddr   = i_head.addr;
        ram_wdata   = 1'b0;
        ram_re      = 1'b0;
        case (r_state)
            ST_SWEEP: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_cnt;
                n_clr_cnt = r_clr_cnt + vob_pkg::ADDR_W'(1);
                if (r_clr_cnt == CLR_LAST) begin
                    n_state   = ST_IDLE;
                    n_clr_cnt = '0;
                end
            end
            ST_IDLE: begin
                if (i_head_valid && out_free) begin
                    o_pop = 1'b1;
                    if (i_head.action == vob_pkg::ACT_CLEAR_ALL) begin
                        load      = 1'b1;
                        n_state   = ST_SWEEP;
                        n_clr_cnt = '0;
                    end else if (!i_head.in_grid) begin
                        load = 1'b1;
                    end else if (i_head.action == vob_pkg::ACT_QUERY) begin
                        ram_re  = 1'b1;
                        n_state = ST_READ;
                    end else begin
                        // Set or clear: the result is the bit just written.
                        ram_we     = 1'b1;
                        ram_wdata  = (i_head.action == vob_pkg::ACT_SET);
                        load       = 1'b1;
                        load_solid = (i_head.action == vob_pkg::ACT_SET);
                    end
                end
            end
            ST_READ: begin
                // The output register was free at issue, so it is empty now.
                load        = 1'b1;
                load_solid  = ram_rdata[0];
                load_inside = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_SWEEP;
            r_clr_cnt <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            if (load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_solid  <= load_solid;
            r_inside <= load_inside;
        end
    end

    vob_ram #(
        .WIDTH(1),
        .DEPTH(vob_pkg::MAP_DEPTH)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(i_head.addr),
        .o_rdata(ram_rdata)
    );

    assign o_status.clearing = (r_state == ST_SWEEP);
    assign o_m_tvalid        = r_m_valid;
    assign o_m_tdata         = {{(vob_pkg::OUT_DATA_W - 2){1'b0}}, r_inside, r_solid};

    `VOB_ASSERT_NOW(a_read_out_empty, r_state == ST_READ, !r_m_valid, "result pending during read")
    `VOB_ASSERT_NOW(a_pop_idle, o_pop, r_state == ST_IDLE, "queue popped while busy")
    `VOB_ASSERT_NEXT(a_query_reads, ram_re, r_state == ST_READ, "query did not enter read")
    `VOB_ASSERT_NEXT(a_sweep_step, i_rst_n && (r_state == ST_SWEEP) && (r_clr_cnt != CLR_LAST), (r_state == ST_SWEEP) && (r_clr_cnt == $past(r_clr_cnt) + 1'b1), "sweep skipped an entry")

endmodule
